@@ sv/bma_pkg.sv @@
// Shared constants, widths and helper functions of the boxcar moving-average block.
`timescale 1ns / 1ps

package bma_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int LEN_W       = 7;
    localparam int SUM_W       = SAMPLE_BITS + PTR_W;
    localparam int FRAC_BITS   = 4;
    localparam int DIVIDEND_W  = SUM_W + FRAC_BITS;
    localparam int REM_W       = LEN_W;
    localparam int STEP_W      = $clog2(DIVIDEND_W);
    localparam int AVG_W       = 20;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = REG_IDX_W'(0);
    localparam logic [LEN_W-1:0]     WINDOW_LENGTH_RESET = LEN_W'(5);

    // Clamp the programmed length into 1..MAX_WINDOW.
    function automatic logic [LEN_W-1:0] active_len(input logic [LEN_W-1:0] wl);
        logic [LEN_W-1:0] m;
        m = wl;
        if (wl == '0) begin
            m = LEN_W'(1);
        end else if (32'(wl) > MAX_WINDOW) begin
            m = LEN_W'(MAX_WINDOW);
        end
        return m;
    endfunction

endpackage

@@ sv/bma_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/bma_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bma_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bma_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [bma_pkg::LEN_W-1:0]        divisor,
    output logic                             busy,
    output logic                             done,
    output logic [bma_pkg::DIVIDEND_W-1:0]   quotient
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [bma_pkg::STEP_W-1:0]      step_reg;
    logic [bma_pkg::REM_W-1:0]       rem_reg;
    logic [bma_pkg::DIVIDEND_W-1:0]  quo_reg;
    logic [bma_pkg::LEN_W-1:0]       div_reg;
    logic [bma_pkg::REM_W:0]         trial;
    logic                            fits;

    // Shift next dividend bit into the partial remainder, then trial-subtract.
    assign trial = {rem_reg, quo_reg[bma_pkg::DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= bma_pkg::STEP_W'(bma_pkg::DIVIDEND_W - 1);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? bma_pkg::REM_W'(trial - {1'b0, div_reg})
                            : bma_pkg::REM_W'(trial);
            quo_reg <= {quo_reg[bma_pkg::DIVIDEND_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/boxcar_moving_average.sv @@
// Boxcar moving-average filter: window sequencer, delay line, running sum and divide.
// Per word: accept, delay-line read, sum update, then for a full window the divide steps,
//   divide handoff and output load. A new word is accepted only once the last has finished
//   this sequence; a result word held by m_ready low stalls the next result and with it
//   the input.
// Reset (aresetn low, synchronous): window cleared, window_length back to 5, no result
//   pending. Delay-line contents are not cleared; only slots written since the last
//   window clear are ever read back.
`timescale 1ns / 1ps

module boxcar_moving_average (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [15:0]                       s_sample,
    input  logic                              s_start_of_block,

    // Result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bma_pkg::AVG_W-1:0]         m_average_q4,

    // Register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bma_pkg::PADDR_W-1:0]       paddr,
    input  logic [bma_pkg::PDATA_W-1:0]       pwdata,
    output logic [bma_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]                          state_reg;
    logic [bma_pkg::SAMPLE_BITS-1:0]     sample_reg;
    logic [bma_pkg::SUM_W-1:0]           sum_reg;
    logic [bma_pkg::SUM_W-1:0]           sum_next;
    logic [bma_pkg::LEN_W-1:0]           fill_reg;
    logic [bma_pkg::LEN_W-1:0]           fill_next;
    logic [bma_pkg::PTR_W-1:0]           wp_reg;
    logic [bma_pkg::LEN_W-1:0]           wl_reg;
    logic                                full_reg;
    logic                                out_valid_reg;
    logic [bma_pkg::AVG_W-1:0]           out_data_reg;

    logic [bma_pkg::LEN_W-1:0]           m_len;
    logic [bma_pkg::PTR_W-1:0]           old_addr;
    logic [bma_pkg::SAMPLE_BITS-1:0]     old_sample;
    logic                                ram_re;
    logic                                ram_we;
    logic                                div_start;
    logic                                div_busy;
    logic                                div_done;
    logic [bma_pkg::DIVIDEND_W-1:0]      div_quotient;
    logic                                cfg_wr;
    logic                                out_load;

    assign m_len = bma_pkg::active_len(wl_reg);

    // Oldest sample in a full window sits window_length slots behind the write pointer;
    // the pointer wraps, so a full-depth window reads the slot about to be overwritten.
    assign old_addr = wp_reg - bma_pkg::PTR_W'(m_len);

    assign ram_re = (state_reg == ST_READ);
    assign ram_we = (state_reg == ST_UPDATE);

    bma_ram #(
        .WIDTH (bma_pkg::SAMPLE_BITS),
        .DEPTH (bma_pkg::MAX_WINDOW)
    ) u_delay_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (old_addr),
        .rdata (old_sample)
    );

    // Recursive sum: add the new sample, drop the leaving one once the window is full.
    always_comb begin
        if (full_reg) begin
            sum_next  = sum_reg + bma_pkg::SUM_W'(sample_reg)
                                - bma_pkg::SUM_W'(old_sample);
            fill_next = m_len;
        end else begin
            sum_next  = sum_reg + bma_pkg::SUM_W'(sample_reg);
            fill_next = fill_reg + 1'b1;
        end
    end

    // Start the divide on sum*16 only when this word completes a full window.
    assign div_start = (state_reg == ST_UPDATE) && (fill_next >= m_len);

    bma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({sum_next, {bma_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (m_len),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Register write decode: any write to window_length also clears the window.
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[bma_pkg::PADDR_W-1:2] == bma_pkg::REG_WINDOW_LENGTH);

    // Result register parts the two sides; hold the finished word until the slot frees.
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            fill_reg      <= '0;
            wp_reg        <= '0;
            wl_reg        <= bma_pkg::WINDOW_LENGTH_RESET;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        // Clear the window ahead of this sample when a block starts.
                        if (s_start_of_block) begin
                            sum_reg  <= '0;
                            fill_reg <= '0;
                            wp_reg   <= '0;
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    full_reg  <= (fill_reg >= m_len);
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    sum_reg   <= sum_next;
                    fill_reg  <= fill_next;
                    wp_reg    <= wp_reg + 1'b1;
                    state_reg <= (fill_next >= m_len) ? ST_DIV : ST_IDLE;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cfg_wr) begin
                wl_reg   <= pwdata[bma_pkg::LEN_W-1:0];
                sum_reg  <= '0;
                fill_reg <= '0;
                wp_reg   <= '0;
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && s_valid) begin
            sample_reg <= s_sample[bma_pkg::SAMPLE_BITS-1:0];
        end
        if (out_load) begin
            out_data_reg <= div_quotient[bma_pkg::AVG_W-1:0];
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_average_q4 = out_data_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[bma_pkg::PADDR_W-1:2] == bma_pkg::REG_WINDOW_LENGTH)
                    ? bma_pkg::PDATA_W'(wl_reg) : '0;

    // Checks on sequencer, divider and window bookkeeping.
    a_ready_not_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_busy)
        else $error("input ready while divider is busy");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= m_len)
        else $error("fill count beyond window length");

    a_start_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> (fill_reg == m_len))
        else $error("divide started without a full window");

endmodule

@@ dv/bma_average_sb_pkg.sv @@
// Scoreboard that predicts and checks the window means of the moving-average block.
`timescale 1ns / 1ps

package bma_average_sb_pkg;

    class average_scoreboard;
        logic [bma_pkg::LEN_W-1:0]       length_reg;
        logic [bma_pkg::SAMPLE_BITS-1:0] history [bma_pkg::MAX_WINDOW];
        logic [bma_pkg::SUM_W-1:0]       window_sum;
        logic [bma_pkg::LEN_W-1:0]       held;
        logic [bma_pkg::PTR_W-1:0]       next_slot;
        logic [bma_pkg::AVG_W-1:0]       awaited_means [$];
        int                              mismatch_count;

        function new();
            length_reg     = bma_pkg::WINDOW_LENGTH_RESET;
            mismatch_count = 0;
            clear_window();
        endfunction

        function void clear_window();
            window_sum = '0;
            held       = '0;
            next_slot  = '0;
        endfunction

        // Zero acts as one; anything past the delay line depth saturates.
        function logic [bma_pkg::LEN_W-1:0] active_span();
            if (length_reg == '0) begin
                return bma_pkg::LEN_W'(1);
            end
            if (length_reg > bma_pkg::LEN_W'(bma_pkg::MAX_WINDOW)) begin
                return bma_pkg::LEN_W'(bma_pkg::MAX_WINDOW);
            end
            return length_reg;
        endfunction

        function void set_length(input logic [bma_pkg::LEN_W-1:0] len);
            length_reg = len;
            clear_window();
        endfunction

        function void take_sample(input logic [15:0] raw, input logic sob);
            logic [bma_pkg::LEN_W-1:0]       span;
            logic [bma_pkg::SAMPLE_BITS-1:0] smp;
            logic [bma_pkg::PTR_W-1:0]       oldest;
            logic [bma_pkg::DIVIDEND_W-1:0]  scaled;
            span = active_span();
            smp  = raw[bma_pkg::SAMPLE_BITS-1:0];
            if (sob) begin
                clear_window();
            end
            if (held >= span) begin
                // Slide: the slot span words back drops out of the window.
                oldest     = next_slot - bma_pkg::PTR_W'(span);
                window_sum = window_sum + bma_pkg::SUM_W'(smp)
                                        - bma_pkg::SUM_W'(history[oldest]);
                held       = span;
            end else begin
                window_sum = window_sum + bma_pkg::SUM_W'(smp);
                held       = held + bma_pkg::LEN_W'(1);
            end
            history[next_slot] = smp;
            next_slot          = next_slot + bma_pkg::PTR_W'(1);
            if (held >= span) begin
                scaled = {window_sum, {bma_pkg::FRAC_BITS{1'b0}}};
                awaited_means.push_back(
                    bma_pkg::AVG_W'(scaled / bma_pkg::DIVIDEND_W'(span)));
            end
        endfunction

        function void check_average(input logic [bma_pkg::AVG_W-1:0] actual);
            logic [bma_pkg::AVG_W-1:0] exp_mean;
            if (awaited_means.size() == 0) begin
                $display("%0t: average_q4 word with none awaited: expected none, actual %0h",
                         $time, actual);
                mismatch_count++;
            end else begin
                exp_mean = awaited_means.pop_front();
                if (actual !== exp_mean) begin
                    $display("%0t: average_q4 differs: expected %0h, actual %0h",
                             $time, exp_mean, actual);
                    mismatch_count++;
                end
            end
        endfunction

        function void check_length_readback(input logic [bma_pkg::PDATA_W-1:0] actual);
            if (actual !== bma_pkg::PDATA_W'(length_reg)) begin
                $display("%0t: window_length readback differs: expected %0h, actual %0h",
                         $time, bma_pkg::PDATA_W'(length_reg), actual);
                mismatch_count++;
            end
        endfunction
    endclass

endpackage

@@ dv/boxcar_moving_average_tb.sv @@
// Self-checking bench for the boxcar moving-average block: directed and random words.
`timescale 1ns / 1ps

module boxcar_moving_average_tb;

    // Register map: window_length at index 0, index 1 is unmapped.
    localparam logic [bma_pkg::PADDR_W-1:0] WINDOW_LENGTH_ADDR =
        bma_pkg::PADDR_W'(bma_pkg::REG_WINDOW_LENGTH) << 2;
    localparam logic [bma_pkg::PADDR_W-1:0] SPARE_REG_ADDR = bma_pkg::PADDR_W'(4);
    // Settle time after the last mean, so that a no-result word can retire.
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_HOLD     = 300;

    logic                          aclk             = 1'b0;
    logic                          aresetn          = 1'b0;
    logic                          s_valid          = 1'b0;
    logic                          s_ready;
    logic [15:0]                   s_sample         = '0;
    logic                          s_start_of_block = 1'b0;
    logic                          m_valid;
    logic                          m_ready          = 1'b0;
    logic [bma_pkg::AVG_W-1:0]     m_average_q4;
    logic                          psel             = 1'b0;
    logic                          penable          = 1'b0;
    logic                          pwrite           = 1'b0;
    logic [bma_pkg::PADDR_W-1:0]   paddr            = '0;
    logic [bma_pkg::PDATA_W-1:0]   pwdata           = '0;
    logic [bma_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    // Knobs shared between the stimulus thread and the result sink.
    bit                            sender_gaps      = 1'b1;
    bit                            sink_stalls      = 1'b1;
    int                            sink_hold_cycles = 0;

    bma_average_sb_pkg::average_scoreboard sb;

    boxcar_moving_average u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_start_of_block (s_start_of_block),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_average_q4     (m_average_q4),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Check every result word on the edge that accepts it.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_average(m_average_q4);
        end
    end

    // Result sink: random stall bursts, plus one long hold-off on request so the
    // block backs up and drops s_ready while words keep being offered.
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (sink_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge aclk);
                sink_hold_cycles = 0;
                m_ready <= 1'b1;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one input word and hold it until accepted. Valid is left high so the
    // next word follows without a bubble; callers lower it when they stop.
    task automatic send_word(input logic [15:0] smp, input logic sob);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_sample         <= smp;
        s_start_of_block <= sob;
        do @(posedge aclk); while (!s_ready);
        sb.take_sample(smp, sob);
    endtask

    // Drop valid, wait out every awaited mean, then let any no-result word retire.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.awaited_means.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [bma_pkg::PADDR_W-1:0] addr,
                             input logic [bma_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr[bma_pkg::PADDR_W-1:2] == bma_pkg::REG_WINDOW_LENGTH) begin
            sb.set_length(data[bma_pkg::LEN_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write window_length with junk in the unused upper bits, then read it back.
    task automatic program_length(input logic [bma_pkg::LEN_W-1:0] len);
        reg_write(WINDOW_LENGTH_ADDR,
                  {(bma_pkg::PDATA_W-bma_pkg::LEN_W)'($urandom()), len});
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= WINDOW_LENGTH_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.check_length_readback(prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Lean on the extremes: full scale and zero show up often.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly blocks that fill the window and slide a while; some are cut short,
    // and some start without a block marker so they run on from the last one.
    task automatic run_phase(input int words);
        int span;
        int sent;
        int run_len;
        span = int'(sb.active_span());
        sent = 0;
        while (sent < words) begin
            if ($urandom_range(0, 9) == 0) begin
                run_len = $urandom_range(1, span);
            end else begin
                run_len = $urandom_range(span, 3 * span + 8);
            end
            for (int i = 0; i < run_len && sent < words; i++) begin
                send_word(pick_sample(), i == 0 && $urandom_range(0, 4) != 0);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [bma_pkg::LEN_W-1:0] phase_len [9];
        phase_len = '{7'd64, 7'd65, 7'd2, 7'd3, 7'd33, 7'd1, 7'd7, 7'd17, 7'd100};
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset length of 5: fill at full scale, slide down to zero, then clear
        // mid-stream and refill with corner values and alternating bit patterns.
        send_word(16'hFFFF, 1'b1);
        repeat (5) send_word(16'hFFFF, 1'b0);
        repeat (5) send_word(16'h0000, 1'b0);
        send_word(16'h0001, 1'b1);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'hAAAA, 1'b0);
        send_word(16'h5555, 1'b0);
        drain();

        // Length zero behaves as a window of one.
        program_length(7'd0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h1234, 1'b1);
        drain();

        // Largest code saturates to the full delay line.
        program_length(7'd127);
        run_phase(200);
        drain();

        foreach (phase_len[p]) begin
            program_length(phase_len[p]);
            if (phase_len[p] == 7'd2) begin
                // Hold the result side off while words keep coming.
                sink_hold_cycles = LONG_HOLD;
            end
            if (phase_len[p] == 7'd7) begin
                // Pause until every mean is out, poke the unmapped register and
                // carry on without a block marker: the window must survive.
                run_phase(60);
                drain();
                reg_write(SPARE_REG_ADDR, $urandom());
                repeat (3) send_word(pick_sample(), 1'b0);
                run_phase(60);
            end else begin
                run_phase(130);
            end
            drain();
        end

        // Closing stretch at full rate on both sides.
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        program_length(7'($urandom_range(1, 64)));
        run_phase(300);
        drain();

        if (sb.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
